FILE: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers used by the reciprocal gamma RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising edge of i_clk while i_rst_n is high.
`define RGM1_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("rgm1 assertion failed");

// Same check with a caller supplied message.
`define RGM1_ASSERT_MSG(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

`endif

FILE: hw/rtl/rgm1_pkg.sv
// ----------------------------------------------------------------------------
// rgm1_pkg
// Shared formats, constants, coefficient tables and helpers of the
// reciprocal gamma minus one pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

package rgm1_pkg;

    localparam int FRAC_BITS = 30;              // fraction bits at the ports
    localparam int IN_W      = 32;
    localparam int OUT_W     = 31;
    localparam int IF_BITS   = 56;              // fraction bits inside
    localparam int FX_W      = 64;
    localparam int LIM_BITS  = 62;              // intermediate values saturate to 2^62
    localparam int IN_SH     = IF_BITS - FRAC_BITS;

    typedef logic signed [FX_W-1:0] t_fx;

    localparam t_fx FX_ONE  = t_fx'(1) <<< IF_BITS;
    localparam t_fx FX_HALF = t_fx'(1) <<< (IF_BITS - 1);
    localparam t_fx FX_LIM  = t_fx'(1) <<< LIM_BITS;

    localparam logic signed [IN_W-1:0] IN_LO = -(IN_W'(1) <<< (FRAC_BITS - 1));
    localparam logic signed [IN_W-1:0] IN_HI = IN_W'(3) <<< (FRAC_BITS - 1);

    // Pipeline depths.
    localparam int MUL_LAT    = 2;
    localparam int HORN_TERMS = 9;
    localparam int HORN_STEPS = HORN_TERMS - 1;
    localparam int HORN_LAT   = HORN_STEPS * (MUL_LAT + 1);
    localparam int DIV_LAT    = LIM_BITS + 2;

    typedef enum logic [2:0] {
        BR_NEG_HI,
        BR_NEG_LO,
        BR_ZERO,
        BR_POS_HI,
        BR_POS_LO
    } t_branch;

    typedef struct packed {
        t_fx     a;
        t_fx     x;
        logic    neg;
        t_branch br;
    } t_side;

    localparam logic [127:0] DEC_SCALE = 128'd1000000000000000000;
    localparam logic [127:0] DEC_HALF  = DEC_SCALE / 2;

    // Decimal coefficient with 18 fraction digits to the internal format,
    // rounded to nearest with ties away from zero.
    function automatic t_fx f_coef(input longint dec);
        logic [127:0] m;
        logic [127:0] q;
        m = (dec < 0) ? 128'(-dec) : 128'(dec);
        q = ((m << IF_BITS) + DEC_HALF) / DEC_SCALE;
        return (dec < 0) ? -$signed(q[FX_W-1:0]) : $signed(q[FX_W-1:0]);
    endfunction

    function automatic logic [FX_W-1:0] f_mag(input t_fx v);
        return (v < 0) ? FX_W'(-v) : FX_W'(v);
    endfunction

    function automatic t_fx f_sat_add(input t_fx a, input t_fx b);
        logic signed [FX_W:0] s;
        s = (FX_W+1)'(a) + (FX_W+1)'(b);
        if (s > (FX_W+1)'(FX_LIM)) begin
            return FX_LIM;
        end
        if (s < -(FX_W+1)'(FX_LIM)) begin
            return -FX_LIM;
        end
        return $signed(s[FX_W-1:0]);
    endfunction

    // Horner tables, lowest order first, padded with zero leading terms.
    localparam t_fx NEG_NUM_TAB [HORN_TERMS] = '{
        f_coef(-64'sd459012296748791300), f_coef(-64'sd911936596342115600),
        f_coef(-64'sd401867055964426600), f_coef(64'sd83953828823965400),
        f_coef(64'sd20104344801791950),   f_coef(-64'sd12713243105649520),
        f_coef(64'sd761856133336163),     f_coef(64'sd566991310926828),
        f_coef(-64'sd115885117926190)
    };
    localparam t_fx NEG_DEN_TAB [HORN_TERMS] = '{
        f_coef(64'sd1085688987606144000), f_coef(64'sd472716182433005000),
        f_coef(64'sd109325430744821400),  f_coef(64'sd12526078081497200),
        '0, '0, '0, '0, '0
    };
    localparam t_fx POS_NUM_TAB [HORN_TERMS] = '{
        f_coef(64'sd472648643403083300),  f_coef(-64'sd180794010082186400),
        f_coef(-64'sd293727877904757000), f_coef(-64'sd10864071557781910),
        f_coef(64'sd15400134259574190),   f_coef(-64'sd2662837428318595),
        '0, '0, '0
    };
    localparam t_fx POS_DEN_TAB [HORN_TERMS] = '{
        f_coef(64'sd818842370613264900), f_coef(64'sd617216001744514600),
        f_coef(64'sd252044615403643800), f_coef(64'sd76231978470549700),
        f_coef(64'sd13424007756566670),  f_coef(64'sd2239198998005776),
        '0, '0, '0
    };

endpackage

`default_nettype wire

FILE: hw/rtl/recip_gamma_minus_one.sv
// ----------------------------------------------------------------------------
// recip_gamma_minus_one
// Streaming evaluator of 1/Gamma(a+1) - 1 for a in [-0.5, 1.5], Q2.30 in
// and Q1.30 out, built as one deep pipeline.
// ----------------------------------------------------------------------------
// The block takes one argument per clock while the output is not stalled
// and returns one result per argument, in order. The pipeline is the input
// register, the two Horner chains, the divider that forms the rational fit,
// one operand select stage, a multiplier, a second divider and the output
// register. Every stage advances together: when a result sits in the output
// register and the sink does not take it, the whole pipeline holds and s_axis
// tready drops, so nothing is lost or repeated and a new transaction can be
// accepted in the very cycle the waiting result leaves. Arguments outside
// [-0.5, 1.5] are clamped. The block has no registers to program and no
// state between items.
`default_nettype none

module recip_gamma_minus_one (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_axis_tvalid,
    output logic             o_s_axis_tready,
    input  wire logic [31:0] i_s_axis_tdata,   // [31:0] argument
    output logic             o_m_axis_tvalid,
    input  wire logic        i_m_axis_tready,
    output logic [31:0]      o_m_axis_tdata    // [30:0] result, [31] zero
);
    import rgm1_pkg::*;

    `include "assert_macros.svh"

    // Alignment points, counted in cycles after the input register.
    localparam int T_HORN = HORN_LAT;
    localparam int T_W    = T_HORN + DIV_LAT;
    localparam int T_OP   = T_W + 1;
    localparam int T_PROD = T_OP + MUL_LAT;
    localparam int T_RES  = T_PROD + DIV_LAT;

    localparam logic signed [OUT_W-1:0] OUT_MAX = {1'b0, {(OUT_W-1){1'b1}}};
    localparam logic signed [OUT_W-1:0] OUT_MIN = {1'b1, {(OUT_W-1){1'b0}}};

    logic w_en;

    // One stall signal for the whole pipe: it moves unless a finished result
    // is still waiting at the output.
    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;

    // ------------------------------------------------------------------
    // Range reduction
    // ------------------------------------------------------------------
    logic signed [IN_W-1:0] w_s;
    t_fx                    w_a, w_x;
    logic                   w_dpos;
    t_side                  n_side;

    always_comb begin
        w_s = $signed(i_s_axis_tdata);
        if (w_s < IN_LO) begin
            w_s = IN_LO;
        end
        if (w_s > IN_HI) begin
            w_s = IN_HI;
        end
        w_a    = t_fx'(w_s) <<< IN_SH;
        // d = a - 0.5; an argument of exactly 0.5 takes the lower branch.
        w_dpos = w_a > FX_HALF;
        w_x    = w_dpos ? (w_a - FX_ONE) : w_a;

        n_side.a   = w_a;
        n_side.x   = w_x;
        n_side.neg = w_x < 0;
        if (w_x < 0) begin
            n_side.br = w_dpos ? BR_NEG_HI : BR_NEG_LO;
        end else if (w_x == 0) begin
            n_side.br = BR_ZERO;
        end else begin
            n_side.br = w_dpos ? BR_POS_HI : BR_POS_LO;
        end
    end

    // Item sideband and valid bits travel in lockstep with the datapath.
    t_side r_side [T_RES+1];
    logic  r_vld  [T_RES+1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= T_RES; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else if (w_en) begin
            r_vld[0] <= i_s_axis_tvalid;
            for (int k = 1; k <= T_RES; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_side[0] <= n_side;
            for (int k = 1; k <= T_RES; k++) begin
                r_side[k] <= r_side[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Rational fit: numerator and denominator in parallel, then w = P/Q.
    // The x/a quotient of the upper positive branch runs alongside.
    // ------------------------------------------------------------------
    t_fx w_num, w_den, w_w, w_xa;

    rgm1_horner u_num (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_tab_neg (NEG_NUM_TAB),
        .i_tab_pos (POS_NUM_TAB),
        .i_x       (r_side[0].x),
        .i_neg     (r_side[0].neg),
        .o_acc     (w_num)
    );

    rgm1_horner u_den (
        .i_clk     (i_clk),
        .i_en      (w_en),
        .i_tab_neg (NEG_DEN_TAB),
        .i_tab_pos (POS_DEN_TAB),
        .i_x       (r_side[0].x),
        .i_neg     (r_side[0].neg),
        .o_acc     (w_den)
    );

    rgm1_div u_div_w (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_num),
        .i_den (w_den),
        .o_quo (w_w)
    );

    rgm1_div u_div_xa (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (r_side[T_HORN].x),
        .i_den (r_side[T_HORN].a),
        .o_quo (w_xa)
    );

    // ------------------------------------------------------------------
    // Operand select for the final product.
    // ------------------------------------------------------------------
    t_fx n_ma, n_mb, r_ma, r_mb;

    always_comb begin
        case (r_side[T_W].br)
            BR_NEG_HI: begin
                n_ma = r_side[T_W].x;
                n_mb = w_w;
            end
            BR_NEG_LO: begin
                n_ma = r_side[T_W].a;
                n_mb = f_sat_add(w_w, FX_ONE);
            end
            BR_POS_HI: begin
                n_ma = w_xa;
                n_mb = f_sat_add(w_w, -FX_ONE);
            end
            BR_POS_LO: begin
                n_ma = r_side[T_W].a;
                n_mb = w_w;
            end
            default: begin
                n_ma = '0;
                n_mb = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_ma <= n_ma;
            r_mb <= n_mb;
        end
    end

    t_fx w_prod, w_dvsr, w_fin;

    rgm1_mul u_mul (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (r_ma),
        .i_b   (r_mb),
        .o_p   (w_prod)
    );

    // Only the upper negative branch divides the product by a. The others
    // divide by one, which returns the product unchanged.
    assign w_dvsr = (r_side[T_PROD].br == BR_NEG_HI) ? r_side[T_PROD].a : FX_ONE;

    rgm1_div u_div_res (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_num (w_prod),
        .i_den (w_dvsr),
        .o_quo (w_fin)
    );

    // ------------------------------------------------------------------
    // Output rounding to Q1.30 and the output register.
    // ------------------------------------------------------------------
    t_fx                     w_res;
    logic [FX_W-1:0]         w_rmag, w_rnd;
    logic signed [OUT_W-1:0] n_out;
    logic signed [OUT_W-1:0] r_out_res;
    logic                    r_out_vld;
    logic                    r_out_zero;

    always_comb begin
        w_res  = (r_side[T_RES].br == BR_ZERO) ? '0 : w_fin;
        w_rmag = f_mag(w_res);
        w_rnd  = (w_rmag + (FX_W'(1) << (IF_BITS - FRAC_BITS - 1))) >> (IF_BITS - FRAC_BITS);
        if (w_res < 0) begin
            n_out = (w_rnd >= FX_W'(1) << (OUT_W - 1)) ? OUT_MIN
                                                       : -$signed(w_rnd[OUT_W-1:0]);
        end else begin
            n_out = (w_rnd > FX_W'(OUT_MAX)) ? OUT_MAX : $signed(w_rnd[OUT_W-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_en) begin
            r_out_vld <= r_vld[T_RES];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_res  <= n_out;
            r_out_zero <= r_side[T_RES].br == BR_ZERO;
        end
    end

    assign o_m_axis_tvalid = r_out_vld;
    assign o_m_axis_tdata  = {1'b0, r_out_res};

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `RGM1_ASSERT(a_stall_holds_input, (o_m_axis_tvalid && !i_m_axis_tready) |-> !o_s_axis_tready)
    `RGM1_ASSERT(a_last_stage_delivers, (w_en && r_vld[T_RES]) |=> o_m_axis_tvalid)
    `RGM1_ASSERT(a_zero_gives_zero, (o_m_axis_tvalid && r_out_zero) |-> (r_out_res == '0))
    `RGM1_ASSERT_MSG(a_reduced_range, r_vld[0] |-> ((r_side[0].x <= FX_HALF) && (r_side[0].x >= -FX_HALF)), "reduced argument outside [-0.5, 0.5]")

endmodule

`default_nettype wire

FILE: hw/rtl/rgm1_mul.sv
// ----------------------------------------------------------------------------
// rgm1_mul
// Two stage fixed-point multiplier: 32x32 partial products, then rounded
// and saturated recombination.
// ----------------------------------------------------------------------------
`default_nettype none

module rgm1_mul (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire rgm1_pkg::t_fx i_a,
    input  wire rgm1_pkg::t_fx i_b,
    output rgm1_pkg::t_fx      o_p
);
    import rgm1_pkg::*;

    logic [FX_W-1:0] w_ma, w_mb;
    logic [63:0]     r_p00, r_p01, r_p10, r_p11;
    logic            r_neg;
    logic [128:0]    w_sum;
    logic [FX_W-1:0] w_q, w_mag;
    logic            w_big;
    t_fx             r_p;

    assign w_ma = f_mag(i_a);
    assign w_mb = f_mag(i_b);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p00 <= 64'(w_ma[31:0])  * 64'(w_mb[31:0]);
            r_p01 <= 64'(w_ma[31:0])  * 64'(w_mb[63:32]);
            r_p10 <= 64'(w_ma[63:32]) * 64'(w_mb[31:0]);
            r_p11 <= 64'(w_ma[63:32]) * 64'(w_mb[63:32]);
            r_neg <= (i_a < 0) != (i_b < 0);
        end
    end

    // The sum carries the rounding constant for the shift by IF_BITS.
    assign w_sum = (129'(r_p11) << 64) + (129'(r_p01) << 32) + (129'(r_p10) << 32)
                 + 129'(r_p00) + (129'(1) << (IF_BITS - 1));
    assign w_big = |w_sum[128:IF_BITS+FX_W];
    assign w_q   = w_sum[IF_BITS+FX_W-1:IF_BITS];
    assign w_mag = (w_big || (w_q > FX_W'(FX_LIM))) ? FX_W'(FX_LIM) : w_q;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= r_neg ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hw/rtl/rgm1_horner.sv
// ----------------------------------------------------------------------------
// rgm1_horner
// Pipelined Horner evaluation, one multiply and add step per three stages,
// with the coefficient set chosen per item by the sign of x.
// ----------------------------------------------------------------------------
`default_nettype none

module rgm1_horner (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire rgm1_pkg::t_fx i_tab_neg [rgm1_pkg::HORN_TERMS],
    input  wire rgm1_pkg::t_fx i_tab_pos [rgm1_pkg::HORN_TERMS],
    input  wire rgm1_pkg::t_fx i_x,
    input  wire logic          i_neg,
    output rgm1_pkg::t_fx      o_acc
);
    import rgm1_pkg::*;

    t_fx  w_acc [HORN_STEPS+1];
    t_fx  w_x   [HORN_STEPS+1];
    logic w_neg [HORN_STEPS+1];

    assign w_acc[0] = i_neg ? i_tab_neg[HORN_TERMS-1] : i_tab_pos[HORN_TERMS-1];
    assign w_x[0]   = i_x;
    assign w_neg[0] = i_neg;

    for (genvar gi = 0; gi < HORN_STEPS; gi++) begin : g_step
        t_fx  w_prod;
        t_fx  w_coef;
        t_fx  r_x_d   [MUL_LAT];
        logic r_neg_d [MUL_LAT];
        t_fx  r_acc;
        t_fx  r_x;
        logic r_neg;

        rgm1_mul u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (w_acc[gi]),
            .i_b   (w_x[gi]),
            .o_p   (w_prod)
        );

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_x_d[0]   <= w_x[gi];
                r_neg_d[0] <= w_neg[gi];
                for (int k = 1; k < MUL_LAT; k++) begin
                    r_x_d[k]   <= r_x_d[k-1];
                    r_neg_d[k] <= r_neg_d[k-1];
                end
            end
        end

        assign w_coef = r_neg_d[MUL_LAT-1] ? i_tab_neg[HORN_STEPS-1-gi]
                                           : i_tab_pos[HORN_STEPS-1-gi];

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_acc <= f_sat_add(w_prod, w_coef);
                r_x   <= r_x_d[MUL_LAT-1];
                r_neg <= r_neg_d[MUL_LAT-1];
            end
        end

        assign w_acc[gi+1] = r_acc;
        assign w_x[gi+1]   = r_x;
        assign w_neg[gi+1] = r_neg;
    end

    assign o_acc = w_acc[HORN_STEPS];

endmodule

`default_nettype wire

FILE: hw/rtl/rgm1_div.sv
// ----------------------------------------------------------------------------
// rgm1_div
// Pipelined restoring divider: rounded (|n| << IF_BITS) / |d|, one quotient
// bit per stage, saturating to 2^62, with the sign applied at the end.
// ----------------------------------------------------------------------------
`default_nettype none

module rgm1_div (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire rgm1_pkg::t_fx i_num,
    input  wire rgm1_pkg::t_fx i_den,
    output rgm1_pkg::t_fx      o_quo
);
    import rgm1_pkg::*;

    localparam int QB     = LIM_BITS;
    localparam int PRE_SH = LIM_BITS - IF_BITS;

    logic [FX_W-1:0] w_mn, w_md;
    logic [FX_W-1:0] r_rem [QB+1];
    logic [QB-1:0]   r_quo [QB+1];
    logic [QB-1:0]   r_low [QB+1];
    logic [FX_W-1:0] r_dv  [QB+1];
    logic            r_neg [QB+1];
    logic            r_sat [QB+1];
    logic            w_rnd;
    logic [FX_W-1:0] w_mag;
    t_fx             r_quo_out;

    assign w_mn = f_mag(i_num);
    assign w_md = f_mag(i_den);

    // A quotient of 2^62 or more saturates, so only 62 bits are developed.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= w_mn >> PRE_SH;
            r_low[0] <= {w_mn[PRE_SH-1:0], {IF_BITS{1'b0}}};
            r_quo[0] <= '0;
            r_dv[0]  <= w_md;
            r_neg[0] <= (i_num < 0) != (i_den < 0);
            r_sat[0] <= {{PRE_SH{1'b0}}, w_mn} >= {w_md, {PRE_SH{1'b0}}};
        end
    end

    for (genvar gj = 0; gj < QB; gj++) begin : g_bit
        logic [FX_W:0] w_try;
        logic [FX_W:0] w_nrem;
        logic          w_ge;

        assign w_try  = {r_rem[gj], r_low[gj][QB-1]};
        assign w_ge   = w_try >= {1'b0, r_dv[gj]};
        assign w_nrem = w_ge ? (w_try - {1'b0, r_dv[gj]}) : w_try;

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[gj+1] <= w_nrem[FX_W-1:0];
                r_quo[gj+1] <= {r_quo[gj][QB-2:0], w_ge};
                r_low[gj+1] <= r_low[gj] << 1;
                r_dv[gj+1]  <= r_dv[gj];
                r_neg[gj+1] <= r_neg[gj];
                r_sat[gj+1] <= r_sat[gj];
            end
        end
    end

    assign w_rnd = r_rem[QB] >= (r_dv[QB] - r_rem[QB]);
    assign w_mag = r_sat[QB] ? FX_W'(FX_LIM) : (FX_W'(r_quo[QB]) + FX_W'(w_rnd));

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_quo_out <= r_neg[QB] ? -$signed(w_mag) : $signed(w_mag);
        end
    end

    assign o_quo = r_quo_out;

endmodule

`default_nettype wire

FILE: verif/recip_gamma_minus_one_chk.sv
// ----------------------------------------------------------------------------
// recip_gamma_minus_one_chk
// Watches both stream channels of the reciprocal gamma block, predicts every
// result from the accepted arguments and compares in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recip_gamma_minus_one_chk (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    input  wire logic        i_s_tready,
    input  wire logic [31:0] i_s_tdata,    // [31:0] argument
    input  wire logic        i_m_tvalid,
    input  wire logic        i_m_tready,
    input  wire logic [31:0] i_m_tdata,    // [30:0] result, [31] zero
    output int               o_pending,
    output int               o_errors
);
    import rgm1_pkg::*;

    localparam logic [63:0]  LIM64   = 64'd1 << LIM_BITS;
    localparam logic [127:0] DEC_SC  = 128'd1000000000000000000;

    localparam longint NEG_NUM [9] = '{
        -64'sd459012296748791300, -64'sd911936596342115600,
        -64'sd401867055964426600, 64'sd83953828823965400,
        64'sd20104344801791950, -64'sd12713243105649520,
        64'sd761856133336163, 64'sd566991310926828, -64'sd115885117926190};
    localparam longint NEG_DEN [9] = '{
        64'sd1085688987606144000, 64'sd472716182433005000,
        64'sd109325430744821400, 64'sd12526078081497200,
        64'sd0, 64'sd0, 64'sd0, 64'sd0, 64'sd0};
    localparam longint POS_NUM [9] = '{
        64'sd472648643403083300, -64'sd180794010082186400,
        -64'sd293727877904757000, -64'sd10864071557781910,
        64'sd15400134259574190, -64'sd2662837428318595,
        64'sd0, 64'sd0, 64'sd0};
    localparam longint POS_DEN [9] = '{
        64'sd818842370613264900, 64'sd617216001744514600,
        64'sd252044615403643800, 64'sd76231978470549700,
        64'sd13424007756566670, 64'sd2239198998005776,
        64'sd0, 64'sd0, 64'sd0};

    logic [30:0] gamma_q[$];

    function automatic logic [63:0] magn(input longint v);
        return (v < 0) ? 64'(-v) : 64'(v);
    endfunction

    function automatic longint signed_sat(input logic [63:0] m, input bit neg);
        if (m > LIM64) m = LIM64;
        return neg ? -longint'(m) : longint'(m);
    endfunction

    // Rounded quotient of magnitudes, saturating at the internal limit.
    function automatic logic [63:0] udiv_rnd(input logic [127:0] num,
                                             input logic [63:0] den);
        logic [127:0] q;
        logic [127:0] r;
        if (den == 0) return LIM64;
        q = num / den;
        r = num % den;
        if (q[127:64] != 0) return LIM64;
        if (r >= 128'(den) - r) q = q + 1;
        return (q > 128'(LIM64)) ? LIM64 : q[63:0];
    endfunction

    function automatic longint fx_plus(input longint a, input longint b);
        longint s;
        s = a + b;
        if (s > longint'(LIM64)) s = longint'(LIM64);
        if (s < -longint'(LIM64)) s = -longint'(LIM64);
        return s;
    endfunction

    function automatic longint fx_times(input longint a, input longint b);
        logic [127:0] p;
        logic [63:0]  q;
        p = 128'(magn(a)) * 128'(magn(b)) + (128'd1 << (IF_BITS - 1));
        if ((p >> IF_BITS) >> 64 != 0) q = LIM64;
        else q = 64'(p >> IF_BITS);
        return signed_sat(q, (a < 0) != (b < 0));
    endfunction

    function automatic longint fx_over(input longint n, input longint d);
        return signed_sat(udiv_rnd(128'(magn(n)) << IF_BITS, magn(d)),
                          (n < 0) != (d < 0));
    endfunction

    function automatic longint dec_to_fx(input longint dec);
        return signed_sat(udiv_rnd(128'(magn(dec)) << IF_BITS, DEC_SC[63:0]),
                          dec < 0);
    endfunction

    function automatic longint poly(input longint c [9], input int n,
                                    input longint x);
        longint acc;
        acc = dec_to_fx(c[n-1]);
        for (int k = n - 2; k >= 0; k--) begin
            acc = fx_plus(fx_times(acc, x), dec_to_fx(c[k]));
        end
        return acc;
    endfunction

    function automatic logic [30:0] gamma_rm1(input logic [31:0] raw);
        longint s, a, d, x, w, res;
        logic [63:0] m;
        s = longint'($signed(raw));
        if (s < -(longint'(1) << 29)) s = -(longint'(1) << 29);
        if (s > 3 * (longint'(1) << 29)) s = 3 * (longint'(1) << 29);
        a = signed_sat(magn(s) << IN_SH, s < 0);
        d = a - (longint'(1) << (IF_BITS - 1));
        x = (d > 0) ? a - (longint'(1) << IF_BITS) : a;
        if (x < 0) begin
            w = fx_over(poly(NEG_NUM, 9, x), poly(NEG_DEN, 4, x));
            if (d > 0) res = fx_over(fx_times(x, w), a);
            else res = fx_times(a, fx_plus(w, longint'(1) << IF_BITS));
        end else if (x == 0) begin
            res = 0;
        end else begin
            w = fx_over(poly(POS_NUM, 6, x), poly(POS_DEN, 6, x));
            if (d > 0) res = fx_times(fx_over(x, a), fx_plus(w, -(longint'(1) << IF_BITS)));
            else res = fx_times(a, w);
        end
        m = (magn(res) + (64'd1 << (IN_SH - 1))) >> IN_SH;
        if (m > (64'd1 << 31)) m = 64'd1 << 31;
        s = (res < 0) ? -longint'(m) : longint'(m);
        if (s > (longint'(1) << 30) - 1) s = (longint'(1) << 30) - 1;
        if (s < -(longint'(1) << 30)) s = -(longint'(1) << 30);
        return s[30:0];
    endfunction

    assign o_pending = gamma_q.size();

    initial o_errors = 0;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && i_s_tready) begin
                gamma_q.push_back(gamma_rm1(i_s_tdata));
            end
            if (i_m_tvalid && i_m_tready) begin
                if (gamma_q.size() == 0) begin
                    $error("result: unexpected transaction, actual %h", i_m_tdata);
                    o_errors <= o_errors + 1;
                end else if (i_m_tdata[30:0] !== gamma_q[0]) begin
                    $error("result: expected %h, actual %h", gamma_q[0],
                           i_m_tdata[30:0]);
                    o_errors <= o_errors + 1;
                    void'(gamma_q.pop_front());
                end else begin
                    void'(gamma_q.pop_front());
                end
            end
        end
    end

endmodule

FILE: verif/recip_gamma_minus_one_tb.sv
// ----------------------------------------------------------------------------
// recip_gamma_minus_one_tb
// Drives arguments into the reciprocal gamma pipeline with random idling on
// both sides; a checker beside the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module recip_gamma_minus_one_tb;

    localparam int N_RANDOM    = 800;
    localparam int CYCLE_LIMIT = 300000;
    // Leave some margin after the last result.
    localparam int DRAIN_WAIT  = 200;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;      // [31:0] argument
    logic        s_tready;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [31:0] m_tdata;           // [30:0] result, [31] zero
    int          pending;
    int          errors;
    bit          idle_on = 1'b1;
    int          sink_stall = 0;
    int          cycles = 0;
    int          n_sent = 0;

    always #1 i_clk = ~i_clk;

    recip_gamma_minus_one u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata)
    );

    recip_gamma_minus_one_chk u_chk (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .o_pending  (pending),
        .o_errors   (errors)
    );

    // The sink stalls in random bursts while idling is enabled.
    always @(posedge i_clk) begin
        if (sink_stall > 0) begin
            sink_stall <= sink_stall - 1;
            m_tready <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
            sink_stall <= $urandom_range(0, 8);
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // Watchdog: a hung pipeline must not run forever.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("recip_gamma_minus_one_tb NOT OK");
            $finish;
        end
    end

    // Presents one argument and holds it until the transaction completes.
    // A random idle burst may follow, during which tvalid is low.
    task automatic send_arg(input logic [31:0] arg);
        s_tvalid <= 1'b1;
        s_tdata  <= arg;
        do @(posedge i_clk); while (!s_tready);
        n_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge i_clk);
        end
    endtask

    // Mostly arguments inside the interval, with the branch boundaries
    // favored; the rest are raw 32-bit words that exercise the clamps.
    function automatic logic [31:0] rand_arg();
        int sel;
        sel = $urandom_range(0, 9);
        case (sel)
            0, 1: return $urandom();
            2: return 32'sd536870912 + $signed($urandom_range(0, 64)) - 32;
            3: return 32'sd1073741824 + $signed($urandom_range(0, 64)) - 32;
            4: return $signed($urandom_range(0, 64)) - 32;
            default: return $urandom_range(0, 32'd2147483648) - 32'd536870912;
        endcase
    endfunction

    initial begin
        logic [31:0] directed [] = '{
            32'hE000_0000,  // lower bound -0.5
            32'h6000_0000,  // upper bound 1.5
            32'h0000_0000,  // zero argument, zero result
            32'h2000_0000,  // exactly 0.5: takes the lower branch
            32'h2000_0001,  // just above 0.5
            32'h1FFF_FFFF,  // just below 0.5
            32'h4000_0000,  // exactly 1: reduced argument is zero
            32'h4000_0001,
            32'h3FFF_FFFF,
            32'h0000_0001,
            32'hFFFF_FFFF,
            32'hDFFF_FFFF,  // just under the lower clamp
            32'h6000_0001,  // just over the upper clamp
            32'h8000_0000,  // most negative word
            32'h7FFF_FFFF,  // most positive word
            32'h1000_0000,
            32'hF000_0000,
            32'h5000_0000,
            32'h3000_0000,
            32'hAAAA_AAAA,
            32'h5555_5555
        };

        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed[i]) send_arg(directed[i]);

        // Let the pipeline drain completely once before the random part.
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(posedge i_clk);

        for (int i = 0; i < N_RANDOM; i++) begin
            // The last stretch runs back to back on both sides.
            if (i == N_RANDOM - 150) idle_on = 1'b0;
            send_arg(rand_arg());
        end
        s_tvalid <= 1'b0;

        wait (pending == 0);
        repeat (DRAIN_WAIT) @(posedge i_clk);

        $display("Sent %0d arguments: bounds, clamps, branch edges and random words,",
                 n_sent);
        $display("with random stalls on both channels and a full drain midway.");
        if (errors == 0 && pending == 0) begin
            $display("recip_gamma_minus_one_tb OK");
        end else begin
            $display("recip_gamma_minus_one_tb NOT OK");
        end
        $finish;
    end

endmodule
